// File: hdl/mmp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI message parser package
// Shared byte types, status codes and parser states.
// ----------------------------------------------------------------------------
package mmp_pkg;

  typedef logic [7:0] midi_byte_t;
  typedef logic [6:0] midi_data_t;
  typedef logic [6:0] midi_len_t;

  localparam midi_byte_t ST_STATUS_MIN = 8'h80;
  localparam midi_byte_t ST_CHAN_MAX   = 8'hEF;
  localparam midi_byte_t ST_SYSEX      = 8'hF0;
  localparam midi_byte_t ST_SYSEX_END  = 8'hF7;
  localparam midi_byte_t ST_REALTIME   = 8'hF8;

  localparam logic [3:0] HI_PROGRAM  = 4'hC;
  localparam logic [3:0] HI_PRESSURE = 4'hD;

  localparam midi_len_t LEN_ONE   = 7'd1;
  localparam midi_len_t LEN_TWO   = 7'd2;
  localparam midi_len_t LEN_THREE = 7'd3;

  typedef enum logic [3:0] {
    PS_IDLE  = 4'b0001,
    PS_CHAN  = 4'b0010,
    PS_SYSEX = 4'b0100,
    PS_RUN   = 4'b1000
  } parse_state_t;

endpackage

// File: hdl/mmp_if.sv
// ----------------------------------------------------------------------------
// MIDI message parser channels
// Valid/ready channels for received bytes and for parsed message words.
// ----------------------------------------------------------------------------
interface mmp_in_if
  import mmp_pkg::*;
  ();
  logic       valid;
  logic       ready;
  midi_byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mmp_out_if
  import mmp_pkg::*;
  ();
  logic       valid;
  logic       ready;
  midi_byte_t msg_status;
  midi_data_t msg_data1;
  midi_data_t msg_data2;
  midi_len_t  msg_length;
  midi_byte_t sysex_byte;
  logic       last_of_run;
  logic       overflow;

  modport source (output valid, output msg_status, output msg_data1, output msg_data2,
                  output msg_length, output sysex_byte, output last_of_run,
                  output overflow, input ready);
  modport sink (input valid, input msg_status, input msg_data1, input msg_data2,
                input msg_length, input sysex_byte, input last_of_run,
                input overflow, output ready);
endinterface

// File: hdl/midi_message_parser.sv
// ----------------------------------------------------------------------------
// MIDI message parser
// Assembles channel, system and system exclusive messages from received bytes.
// ----------------------------------------------------------------------------
// Timing: a channel or single-byte message word is valid in the cycle after its
// last byte is accepted; 0xF7 enters PS_RUN, which registers the run's words.
// Throughput: one byte per cycle outside a run while the output is free; a run
// holds the input, one word per cycle from the read port while output is free.
// Reset: synchronous rst_n clears the parser and output valid; the buffer is
// not cleared, since every entry is written before it is read.
module midi_message_parser
  import mmp_pkg::*;
#(
  parameter int SYSEX_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  mmp_in_if.sink         in_ch,
  mmp_out_if.source      out_ch
);

  localparam int AW = $clog2(SYSEX_DEPTH);
  localparam int LW = $clog2(SYSEX_DEPTH + 1);

  parse_state_t   st_r, st_nxt;
  midi_byte_t     held_r, held_nxt;
  midi_data_t     first_r, first_nxt;
  logic           two_r, two_nxt;
  logic           seen_r, seen_nxt;
  logic [AW-1:0]  slen_r, slen_nxt;
  logic           drop_r, drop_nxt;
  logic [LW-1:0]  run_len_r, run_len_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;

  logic           out_valid_r, out_valid_nxt;
  midi_byte_t     out_status_r;
  midi_data_t     out_d1_r;
  midi_data_t     out_d2_r;
  midi_len_t      out_len_r;
  logic           out_last_r;
  logic           out_ovf_r;
  logic           out_sx_r;

  logic           out_free;
  logic           in_acc;
  logic           as_idle;
  logic           is_last;
  midi_byte_t     rx;

  logic           load;
  midi_byte_t     ld_status;
  midi_data_t     ld_d1;
  midi_data_t     ld_d2;
  midi_len_t      ld_len;
  logic           ld_last;
  logic           ld_ovf;
  logic           ld_sx;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic           ram_re;
  midi_byte_t     ram_rdata;

  assign rx       = in_ch.rx_byte;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (st_r != PS_RUN) && out_free;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign is_last  = (LW'(idx_r) + LW'(1)) == run_len_r;

  always_comb begin
    st_nxt      = st_r;
    held_nxt    = held_r;
    first_nxt   = first_r;
    two_nxt     = two_r;
    seen_nxt    = seen_r;
    slen_nxt    = slen_r;
    drop_nxt    = drop_r;
    run_len_nxt = run_len_r;
    idx_nxt     = idx_r;
    ram_we      = 1'b0;
    ram_waddr   = slen_r;
    ram_re      = 1'b0;
    as_idle     = 1'b0;
    load        = 1'b0;
    ld_status   = rx;
    ld_d1       = '0;
    ld_d2       = '0;
    ld_len      = LEN_ONE;
    ld_last     = 1'b1;
    ld_ovf      = 1'b0;
    ld_sx       = 1'b0;

    case (st_r)
      PS_IDLE: begin
        if (in_acc) begin
          as_idle = 1'b1;
        end
      end
      PS_CHAN: begin
        if (in_acc) begin
          if (rx >= ST_REALTIME) begin
            load = 1'b1;
          end else if (rx[7]) begin
            as_idle = 1'b1;
          end else if (!seen_r && two_r) begin
            first_nxt = rx[6:0];
            seen_nxt  = 1'b1;
          end else begin
            load      = 1'b1;
            ld_status = held_r;
            if (two_r) begin
              ld_d1  = first_r;
              ld_d2  = rx[6:0];
              ld_len = LEN_THREE;
            end else begin
              ld_d1  = rx[6:0];
              ld_len = LEN_TWO;
            end
            st_nxt   = PS_IDLE;
            seen_nxt = 1'b0;
          end
        end
      end
      PS_SYSEX: begin
        if (in_acc) begin
          if (rx >= ST_REALTIME) begin
            load = 1'b1;
          end else if (rx == ST_SYSEX_END) begin
            ram_we      = 1'b1;
            run_len_nxt = LW'(slen_r) + LW'(1);
            idx_nxt     = '0;
            st_nxt      = PS_RUN;
          end else if (rx[7]) begin
            slen_nxt = '0;
            drop_nxt = 1'b0;
            as_idle  = 1'b1;
          end else if (slen_r != AW'(SYSEX_DEPTH - 1)) begin
            ram_we   = 1'b1;
            slen_nxt = slen_r + AW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
        end
      end
      PS_RUN: begin
        if (out_free) begin
          ram_re    = 1'b1;
          load      = 1'b1;
          ld_status = ST_SYSEX;
          ld_len    = midi_len_t'(run_len_r);
          ld_last   = is_last;
          ld_ovf    = drop_r;
          ld_sx     = 1'b1;
          if (is_last) begin
            st_nxt   = PS_IDLE;
            slen_nxt = '0;
            drop_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
      default: begin
        st_nxt = PS_IDLE;
      end
    endcase

    if (as_idle) begin
      st_nxt = PS_IDLE;
      if (rx inside {[ST_STATUS_MIN:ST_CHAN_MAX]}) begin
        held_nxt  = rx;
        first_nxt = '0;
        seen_nxt  = 1'b0;
        two_nxt   = !((rx[7:4] == HI_PROGRAM) || (rx[7:4] == HI_PRESSURE));
        st_nxt    = PS_CHAN;
      end else if (rx == ST_SYSEX) begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        slen_nxt  = AW'(1);
        drop_nxt  = 1'b0;
        st_nxt    = PS_SYSEX;
      end else if (rx[7]) begin
        load = 1'b1;
      end
    end
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= PS_IDLE;
      held_r      <= '0;
      first_r     <= '0;
      two_r       <= 1'b0;
      seen_r      <= 1'b0;
      slen_r      <= '0;
      drop_r      <= 1'b0;
      run_len_r   <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      out_sx_r    <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      held_r      <= held_nxt;
      first_r     <= first_nxt;
      two_r       <= two_nxt;
      seen_r      <= seen_nxt;
      slen_r      <= slen_nxt;
      drop_r      <= drop_nxt;
      run_len_r   <= run_len_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (load) begin
        out_sx_r <= ld_sx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= ld_status;
      out_d1_r     <= ld_d1;
      out_d2_r     <= ld_d2;
      out_len_r    <= ld_len;
      out_last_r   <= ld_last;
      out_ovf_r    <= ld_ovf;
    end
  end

  mmp_sysex_ram #(
    .DEPTH (SYSEX_DEPTH),
    .AW    (AW)
  ) u_sysex_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rx),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.msg_status  = out_status_r;
  assign out_ch.msg_data1   = out_d1_r;
  assign out_ch.msg_data2   = out_d2_r;
  assign out_ch.msg_length  = out_len_r;
  assign out_ch.sysex_byte  = out_sx_r ? ram_rdata : '0;
  assign out_ch.last_of_run = out_last_r;
  assign out_ch.overflow    = out_ovf_r;

  a_run_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sx_r) |-> (out_status_r == ST_SYSEX))
    else $error("System exclusive word without sysex status.");

  a_run_index: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == PS_RUN) |-> ((LW'(idx_r) < run_len_r) && (run_len_r != '0)))
    else $error("Run index beyond run length.");

  a_slen_range: assert property (@(posedge clk) disable iff (!rst_n)
    slen_r <= AW'(SYSEX_DEPTH - 1))
    else $error("System exclusive count past the end slot.");

  a_end_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (st_r == PS_SYSEX) && (rx == ST_SYSEX_END)) |=> (st_r == PS_RUN))
    else $error("End of system exclusive did not start a run.");

endmodule

// File: hdl/mmp_sysex_ram.sv
// ----------------------------------------------------------------------------
// System exclusive buffer
// One write port and one read port with a registered read word.
// ----------------------------------------------------------------------------
module mmp_sysex_ram
  import mmp_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  midi_byte_t      wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output midi_byte_t      rdata
);

  midi_byte_t mem_r [DEPTH];
  midi_byte_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: verif/midi_message_parser_test.sv
// ----------------------------------------------------------------------------
// MIDI message parser testbench
// Drives received bytes into the parser and checks every message word against
// a behavioral predictor: directed channel and system cases, a full and an
// overflowing system exclusive run, a long output stall that backs up the
// input, and a random mix of well-formed, truncated and noisy traffic.
// ----------------------------------------------------------------------------
module midi_message_parser_test;
  import mmp_pkg::*;

  localparam int DEPTH       = 64;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    midi_byte_t status;
    midi_data_t data1;
    midi_data_t data2;
    midi_len_t  length;
    midi_byte_t sx;
    logic       last_of_run;
    logic       ovf;
  } midi_word_t;

  logic clk = 1'b0;
  logic rst_n;

  mmp_in_if  in_ch ();
  mmp_out_if out_ch ();

  midi_message_parser #(.SYSEX_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  midi_word_t     pending_words[$];
  int             errors = 0;
  int             bytes_sent = 0;
  int             quiet_cycles = 0;
  int             rx_hold_cycles = 0;
  bit             tx_gaps = 1'b1;
  bit             rx_stalls = 1'b1;

  parse_state_t   phase = PS_IDLE;
  midi_byte_t     held_status = '0;
  midi_data_t     first_data = '0;
  int             data_needed = 0;
  int             data_seen = 0;
  midi_byte_t     sysex_buf[DEPTH];
  int             sysex_cnt = 0;
  logic           sysex_lost = 1'b0;

  function automatic void push_word(midi_byte_t st, midi_data_t d1, midi_data_t d2,
                                    midi_len_t len, midi_byte_t sx, logic lst, logic ovf);
    midi_word_t w;
    w.status      = st;
    w.data1       = d1;
    w.data2       = d2;
    w.length      = len;
    w.sx          = sx;
    w.last_of_run = lst;
    w.ovf         = ovf;
    pending_words.push_back(w);
  endfunction

  function automatic void open_message(midi_byte_t b);
    if (b < ST_STATUS_MIN) begin
      phase = PS_IDLE;
    end else if (b < ST_SYSEX) begin
      held_status = b;
      first_data  = '0;
      data_seen   = 0;
      data_needed = (b[7:4] == HI_PROGRAM || b[7:4] == HI_PRESSURE) ? 1 : 2;
      phase       = PS_CHAN;
    end else if (b == ST_SYSEX) begin
      sysex_buf[0] = b;
      sysex_cnt    = 1;
      sysex_lost   = 1'b0;
      phase        = PS_SYSEX;
    end else begin
      push_word(b, '0, '0, LEN_ONE, '0, 1'b1, 1'b0);
    end
  endfunction

  function automatic void parse_byte(midi_byte_t b);
    int n;
    if (b >= ST_REALTIME) begin
      push_word(b, '0, '0, LEN_ONE, '0, 1'b1, 1'b0);
    end else if (phase == PS_CHAN) begin
      if (b >= ST_STATUS_MIN) begin
        phase = PS_IDLE;
        open_message(b);
      end else if (data_seen == 0 && data_needed > 1) begin
        first_data = b[6:0];
        data_seen  = 1;
      end else begin
        if (data_needed > 1) begin
          push_word(held_status, first_data, b[6:0], LEN_THREE, '0, 1'b1, 1'b0);
        end else begin
          push_word(held_status, b[6:0], '0, LEN_TWO, '0, 1'b1, 1'b0);
        end
        phase     = PS_IDLE;
        data_seen = 0;
      end
    end else if (phase == PS_SYSEX) begin
      if (b == ST_SYSEX_END) begin
        n = (sysex_cnt > DEPTH - 1) ? DEPTH - 1 : sysex_cnt;
        sysex_buf[n] = b;
        n++;
        for (int k = 0; k < n; k++) begin
          push_word(ST_SYSEX, '0, '0, midi_len_t'(n), sysex_buf[k], k == n - 1, sysex_lost);
        end
        phase      = PS_IDLE;
        sysex_cnt  = 0;
        sysex_lost = 1'b0;
      end else if (b >= ST_STATUS_MIN) begin
        phase      = PS_IDLE;
        sysex_cnt  = 0;
        sysex_lost = 1'b0;
        open_message(b);
      end else if (sysex_cnt < DEPTH - 1) begin
        sysex_buf[sysex_cnt] = b;
        sysex_cnt++;
      end else begin
        sysex_lost = 1'b1;
      end
    end else begin
      phase = PS_IDLE;
      open_message(b);
    end
  endfunction

  task automatic send_byte(midi_byte_t b);
    int gap;
    @(negedge clk);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
    parse_byte(b);
    bytes_sent++;
  endtask

  // Real-time bytes may land before any data byte of a message.
  task automatic send_data(midi_byte_t b);
    if ($urandom_range(0, 15) == 0) begin
      send_byte(midi_byte_t'($urandom_range(ST_REALTIME, 8'hFF)));
    end
    send_byte(b);
  endtask

  task automatic send_sysex(int count, midi_byte_t tail);
    send_byte(ST_SYSEX);
    repeat (count) send_data(midi_byte_t'($urandom_range(0, 127)));
    send_byte(tail);
  endtask

  task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    midi_word_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_words.size() == 0) begin
        $error("msg_status: expected no word, got %0h", out_ch.msg_status);
        errors++;
      end else begin
        want = pending_words.pop_front();
        check_field("msg_status", want.status, out_ch.msg_status);
        check_field("msg_data1", want.data1, out_ch.msg_data1);
        check_field("msg_data2", want.data2, out_ch.msg_data2);
        check_field("msg_length", want.length, out_ch.msg_length);
        check_field("sysex_byte", want.sx, out_ch.sysex_byte);
        check_field("last_of_run", want.last_of_run, out_ch.last_of_run);
        check_field("overflow", want.ovf, out_ch.overflow);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 11);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_channel_messages();
    midi_byte_t seq[] = '{8'h00, 8'h7F, 8'h90, 8'h00, 8'h7F, 8'hC5, 8'h7F, 8'hDF,
                          8'h00, 8'hE3, 8'h40, 8'hF8, 8'h01, 8'hB0, 8'h10, 8'hA0,
                          8'h22, 8'h33, 8'h80, 8'h01, 8'h02, 8'hEF, 8'h7F, 8'h7F};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_system_messages();
    midi_byte_t seq[] = '{8'hF7, 8'hF1, 8'hFF, 8'hF0, 8'hF7, 8'hF0, 8'h01, 8'h7F,
                          8'hFA, 8'hF7, 8'hF0, 8'h05, 8'h80, 8'h11, 8'h22, 8'hF0,
                          8'h06, 8'hE5, 8'h07, 8'h08, 8'hF0, 8'hF6, 8'hB0, 8'h01,
                          8'hF7};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_sysex_overflow();
    send_sysex(DEPTH - 2, ST_SYSEX_END);
    send_sysex(DEPTH + 11, ST_SYSEX_END);
  endtask

  // The output stays blocked long enough for a whole run to back up into the
  // input while further words are still being offered.
  task automatic test_backpressure();
    rx_hold_cycles = 400;
    send_sysex(40, ST_SYSEX_END);
    repeat (3) begin
      send_byte(8'h90);
      send_byte(midi_byte_t'($urandom_range(0, 127)));
      send_byte(midi_byte_t'($urandom_range(0, 127)));
    end
  endtask

  task automatic test_random_traffic();
    int base;
    int kind;
    int needed;
    midi_byte_t b;
    base = bytes_sent;
    while (bytes_sent - base < 30) begin
      if (bytes_sent - base > 15) begin
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
      end
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        b = midi_byte_t'($urandom_range(ST_STATUS_MIN, ST_CHAN_MAX));
        needed = (b[7:4] == HI_PROGRAM || b[7:4] == HI_PRESSURE) ? 1 : 2;
        if ($urandom_range(0, 9) == 0) needed--;
        send_byte(b);
        repeat (needed) send_data(midi_byte_t'($urandom_range(0, 127)));
      end else if (kind < 60) begin
        send_sysex(($urandom_range(0, 9) == 0) ? $urandom_range(60, 75) : $urandom_range(0, 12),
                   ($urandom_range(0, 9) == 0) ?
                   midi_byte_t'($urandom_range(ST_STATUS_MIN, ST_SYSEX_END - 1)) :
                   ST_SYSEX_END);
      end else if (kind < 75) begin
        send_byte(midi_byte_t'($urandom_range(ST_SYSEX + 1, ST_SYSEX_END)));
      end else if (kind < 85) begin
        send_byte(midi_byte_t'($urandom_range(ST_REALTIME, 8'hFF)));
      end else begin
        b = midi_byte_t'($urandom_range(0, 255));
        send_byte(b);
        if (b < ST_STATUS_MIN) bytes_sent--;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_channel_messages();
    test_system_messages();
    test_sysex_overflow();
    test_backpressure();
    test_random_traffic();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
